// ===== src/array_doubly_linked_list_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH
`define ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH

// Same-cycle implication under the block clock and reset.
`define ADLL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under the block clock and reset.
`define ADLL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/adll_pkg.sv =====
`timescale 1ns / 1ps
package adll_pkg;

    localparam int NODES   = 1024;
    localparam int SLOTS   = NODES + 2;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ALLOC_W = $clog2(SLOTS + 1);
    localparam int ORD_W   = 11;
    localparam int CMD_W   = 3;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [ORD_W-1:0]  t_ord;

    localparam t_slot HEAD_SLOT = t_slot'(0);
    localparam t_slot TAIL_SLOT = t_slot'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT  = 3'd0,
        CMD_PUSH_BACK   = 3'd1,
        CMD_DELETE      = 3'd2,
        CMD_INSERT_LEFT = 3'd3,
        CMD_INSERT_RIGHT= 3'd4,
        CMD_READ        = 3'd5
    } t_cmd;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FILL,
        S_LINK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_slot slot_addr;
        t_slot value_addr;
    } t_rd_req;

    typedef struct packed {
        t_slot             next;
        t_slot             prev;
        logic [VAL_W-1:0]  value;
        logic              alive;
    } t_rd_data;

    typedef struct packed {
        logic              next_we;
        t_slot             next_addr;
        t_slot             next_data;
        logic              prev_we;
        t_slot             prev_addr;
        t_slot             prev_data;
        logic              value_we;
        t_slot             value_addr;
        logic [VAL_W-1:0]  value_data;
        logic              alive_we;
        t_slot             alive_addr;
        logic              alive_data;
    } t_wr_req;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        t_ord                new_node;
        logic signed [VAL_W-1:0] read_value;
        t_ord                next_node;
        t_ord                prev_node;
    } t_result;

    function automatic t_slot ord_to_slot(input t_ord o);
        return t_slot'(o) + t_slot'(1);
    endfunction

    function automatic t_ord slot_to_ord(input t_slot s);
        return (s < t_slot'(2)) ? t_ord'(0) : t_ord'(s - t_slot'(1));
    endfunction

endpackage

// ===== src/adll_store.sv =====
`timescale 1ns / 1ps
module adll_store
    import adll_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rd_req  i_rd,
    input  t_wr_req  i_wr,
    output t_rd_data o_rd,
    output t_slot    o_head_next,
    output t_slot    o_tail_prev
);

    t_slot            r_next_mem  [SLOTS];
    t_slot            r_prev_mem  [SLOTS];
    logic [VAL_W-1:0] r_value_mem [SLOTS];
    logic             r_alive_mem [SLOTS];

    t_slot r_head_next;
    t_slot r_tail_prev;
    t_slot r_next_rd;
    t_slot r_prev_rd;
    logic [VAL_W-1:0] r_value_rd;
    logic  r_alive_rd;

    // Sentinel links live in flops so reset gives them at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_next <= TAIL_SLOT;
            r_tail_prev <= HEAD_SLOT;
        end else begin
            if (i_wr.next_we && i_wr.next_addr == HEAD_SLOT) begin
                r_head_next <= i_wr.next_data;
            end
            if (i_wr.prev_we && i_wr.prev_addr == TAIL_SLOT) begin
                r_tail_prev <= i_wr.prev_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.next_we) begin
            r_next_mem[i_wr.next_addr] <= i_wr.next_data;
        end
        r_next_rd <= r_next_mem[i_rd.slot_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.prev_we) begin
            r_prev_mem[i_wr.prev_addr] <= i_wr.prev_data;
        end
        r_prev_rd <= r_prev_mem[i_rd.slot_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.value_we) begin
            r_value_mem[i_wr.value_addr] <= i_wr.value_data;
        end
        r_value_rd <= r_value_mem[i_rd.value_addr];
    end

    // Entries at or above the bump counter are never trusted, so no clear pass.
    always_ff @(posedge i_clk) begin
        if (i_wr.alive_we) begin
            r_alive_mem[i_wr.alive_addr] <= i_wr.alive_data;
        end
        r_alive_rd <= r_alive_mem[i_rd.slot_addr];
    end

    assign o_rd.next    = r_next_rd;
    assign o_rd.prev    = r_prev_rd;
    assign o_rd.value   = r_value_rd;
    assign o_rd.alive   = r_alive_rd;
    assign o_head_next  = r_head_next;
    assign o_tail_prev  = r_tail_prev;

endmodule

// ===== src/adll_ctrl.sv =====
`timescale 1ns / 1ps
module adll_ctrl
    import adll_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  t_ord             i_ord,
    input  logic [VAL_W-1:0] i_val,
    input  logic             i_out_free,
    input  t_rd_data         i_rd,
    input  t_slot            i_head_next,
    input  t_slot            i_tail_prev,
    output logic             o_in_ready,
    output t_rd_req          o_rd,
    output t_wr_req          o_wr,
    output logic             o_res_valid,
    output t_result          o_res
);

    t_state r_state, n_state;
    logic [CMD_W-1:0] r_cmd;
    t_ord             r_ord;
    logic [VAL_W-1:0] r_val;
    logic [ALLOC_W-1:0] r_alloc;
    t_slot   r_a, n_a;
    t_slot   r_b, n_b;
    t_slot   r_na, n_na;
    t_slot   r_pb, n_pb;
    t_result r_res, n_res;

    t_slot r_slot;
    t_slot w_n;
    t_slot w_in_slot;
    logic  w_create;
    logic  w_target;
    logic  w_bad;
    logic  w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_alloc <= ALLOC_W'(2);
        end else begin
            r_state <= n_state;
            if (r_state == S_FILL) begin
                r_alloc <= r_alloc + ALLOC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd  <= i_cmd;
            r_ord  <= i_ord;
            r_val  <= i_val;
            r_slot <= w_in_slot;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_na  <= n_na;
        r_pb  <= n_pb;
        r_res <= n_res;
    end

    assign w_in_slot = ord_to_slot(i_ord);
    assign w_n       = r_alloc[SLOT_W-1:0];

    // Look up the target row while the word is taken.
    always_comb begin
        o_rd.slot_addr  = w_in_slot;
        o_rd.value_addr = (i_cmd == CMD_READ && i_ord == t_ord'(0)) ? i_head_next : w_in_slot;
    end

    assign w_create = (r_cmd == CMD_PUSH_FRONT) || (r_cmd == CMD_PUSH_BACK) ||
                      (r_cmd == CMD_INSERT_LEFT) || (r_cmd == CMD_INSERT_RIGHT);
    assign w_target = (r_cmd == CMD_DELETE) || (r_cmd == CMD_INSERT_LEFT) ||
                      (r_cmd == CMD_INSERT_RIGHT) ||
                      (r_cmd == CMD_READ && r_ord != t_ord'(0));
    assign w_bad    = w_target && (r_ord == t_ord'(0) || 32'(r_ord) > 32'(NODES) ||
                      32'(r_slot) >= 32'(r_alloc) || !i_rd.alive);
    assign w_full   = !w_bad && w_create && 32'(r_alloc) >= 32'(SLOTS);

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_na        = r_na;
        n_pb        = r_pb;
        n_res       = r_res;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_wr        = '0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_res   = '0;
                n_state = S_DONE;
                n_na    = w_n;
                n_pb    = w_n;
                if (w_bad) begin
                    n_res.status = ST_BAD;
                end else if (w_full) begin
                    n_res.status = ST_FULL;
                end else begin
                    if (w_create) begin
                        n_res.new_node = slot_to_ord(w_n);
                        n_state        = S_FILL;
                    end
                    unique case (r_cmd)
                        CMD_PUSH_FRONT: begin
                            n_a = HEAD_SLOT;
                            n_b = i_head_next;
                        end
                        CMD_PUSH_BACK: begin
                            n_a = i_tail_prev;
                            n_b = TAIL_SLOT;
                        end
                        CMD_INSERT_LEFT: begin
                            n_a = i_rd.prev;
                            n_b = r_slot;
                        end
                        CMD_INSERT_RIGHT: begin
                            n_a = r_slot;
                            n_b = i_rd.next;
                        end
                        CMD_DELETE: begin
                            // Splice the neighbors around the target.
                            n_a     = i_rd.prev;
                            n_b     = i_rd.next;
                            n_na    = i_rd.next;
                            n_pb    = i_rd.prev;
                            n_state = S_LINK;
                        end
                        CMD_READ: begin
                            if (r_ord == t_ord'(0)) begin
                                n_res.next_node  = slot_to_ord(i_head_next);
                                n_res.read_value = (i_head_next >= t_slot'(2)) ?
                                                   i_rd.value : '0;
                            end else begin
                                n_res.read_value = i_rd.value;
                                n_res.next_node  = slot_to_ord(i_rd.next);
                                n_res.prev_node  = slot_to_ord(i_rd.prev);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                o_wr.next_we    = 1'b1;
                o_wr.next_addr  = w_n;
                o_wr.next_data  = r_b;
                o_wr.prev_we    = 1'b1;
                o_wr.prev_addr  = w_n;
                o_wr.prev_data  = r_a;
                o_wr.value_we   = 1'b1;
                o_wr.value_addr = w_n;
                o_wr.value_data = r_val;
                o_wr.alive_we   = 1'b1;
                o_wr.alive_addr = w_n;
                o_wr.alive_data = 1'b1;
                n_state         = S_LINK;
            end
            S_LINK: begin
                o_wr.next_we    = 1'b1;
                o_wr.next_addr  = r_a;
                o_wr.next_data  = r_na;
                o_wr.prev_we    = 1'b1;
                o_wr.prev_addr  = r_b;
                o_wr.prev_data  = r_pb;
                o_wr.alive_we   = (r_cmd == CMD_DELETE);
                o_wr.alive_addr = r_slot;
                o_wr.alive_data = 1'b0;
                n_state         = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register can take the word.
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

// ===== src/array_doubly_linked_list.sv =====
`timescale 1ns / 1ps
// Doubly linked list kept in a pool of 1024 nodes, between a head and a tail sentinel.
// Each input word is one command (push front or back, delete, insert left or right of a
// node, read) and gives exactly one result word; nodes are numbered 1, 2, ... in order of
// creation and never reused. The block works on one command at a time and is not ready
// meanwhile: a read or rejected command goes from S_CHECK to S_DONE, a delete via S_LINK,
// a create via S_FILL and S_LINK. S_DONE loads the result register once the result
// side is free, and the next word is taken back in S_IDLE. This order follows from the
// registered lookup of the target row and the single write port of each link memory,
// which gives a create a fill and a link state. No clearing pass is needed after reset:
// rows at or above the allocation counter are never trusted.
module array_doubly_linked_list
    import adll_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // command[2:0], node[13:3], value[45:14]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata   // status, new_node, read_value, next_node, prev_node
);

    t_rd_req  w_rd_req;
    t_wr_req  w_wr_req;
    t_rd_data w_rd_data;
    t_slot    w_head_next;
    t_slot    w_tail_prev;
    logic     w_res_valid;
    t_result  w_res;
    logic     w_out_free;

    logic        r_m_valid;
    logic [71:0] r_m_data;

    assign w_out_free = !r_m_valid || i_m_tready;

    adll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_cmd       (i_s_tdata[2:0]),
        .i_ord       (i_s_tdata[13:3]),
        .i_val       (i_s_tdata[45:14]),
        .i_out_free  (w_out_free),
        .i_rd        (w_rd_data),
        .i_head_next (w_head_next),
        .i_tail_prev (w_tail_prev),
        .o_in_ready  (o_s_tready),
        .o_rd        (w_rd_req),
        .o_wr        (w_wr_req),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    adll_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (w_rd_req),
        .i_wr        (w_wr_req),
        .o_rd        (w_rd_data),
        .o_head_next (w_head_next),
        .o_tail_prev (w_tail_prev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_m_data <= {5'b0, w_res.prev_node, w_res.next_node, w_res.read_value,
                         w_res.new_node, w_res.status};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

// ===== src/adll_checker.sv =====
`timescale 1ns / 1ps
`include "array_doubly_linked_list_macros.svh"
module adll_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata
);

    `ADLL_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n,
                     i_s_tvalid && o_s_tready, !o_s_tready,
                     "block ready right after taking a command")
    `ADLL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
                     o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata),
                     "stalled result changed")
    `ADLL_ASSERT_IMP(a_err_fields_zero, i_clk, i_rst_n,
                     o_m_tvalid && o_m_tdata[1:0] != 2'd0, o_m_tdata[71:2] == 70'd0,
                     "failed command carries data")
    `ADLL_ASSERT_IMP(a_status_code, i_clk, i_rst_n,
                     o_m_tvalid, o_m_tdata[1:0] != 2'd3,
                     "undefined status code")

endmodule

bind array_doubly_linked_list adll_checker u_adll_checker (.*);
